@@ rtl/core/qtam_pkg.sv @@
`default_nettype none

package qtam_pkg;

   // field and datapath widths
   localparam int WORD_W   = 32;
   localparam int AXES     = 3;
   localparam int N_ENT    = 9;
   localparam int ROT_FRAC = 30;
   localparam int RATIO_W  = ROT_FRAC + 1;
   localparam int SQ_W     = 62;
   localparam int SUM_W    = 63;
   localparam int NUM_W    = 64;
   localparam int DEN_W    = 63;
   localparam int REM_W    = 62;
   localparam int PROD_W   = 62;

   typedef struct packed {
      logic signed [WORD_W-1:0] quat_x;
      logic signed [WORD_W-1:0] quat_y;
      logic signed [WORD_W-1:0] quat_z;
      logic signed [WORD_W-1:0] quat_w;
      logic signed [WORD_W-1:0] scale_x;
      logic signed [WORD_W-1:0] scale_y;
      logic signed [WORD_W-1:0] scale_z;
      logic signed [WORD_W-1:0] shift_x;
      logic signed [WORD_W-1:0] shift_y;
      logic signed [WORD_W-1:0] shift_z;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] col0_row0;
      logic signed [WORD_W-1:0] col0_row1;
      logic signed [WORD_W-1:0] col0_row2;
      logic signed [WORD_W-1:0] col1_row0;
      logic signed [WORD_W-1:0] col1_row1;
      logic signed [WORD_W-1:0] col1_row2;
      logic signed [WORD_W-1:0] col2_row0;
      logic signed [WORD_W-1:0] col2_row1;
      logic signed [WORD_W-1:0] col2_row2;
      logic signed [WORD_W-1:0] col3_row0;
      logic signed [WORD_W-1:0] col3_row1;
      logic signed [WORD_W-1:0] col3_row2;
   } rsp_type;

   // scale magnitudes, scale signs and translation carried alongside
   typedef struct packed {
      logic [AXES-1:0][WORD_W-1:0] smag;
      logic [AXES-1:0]             sneg;
      logic [AXES-1:0][WORD_W-1:0] shift;
   } xf_type;

   typedef struct packed {
      logic [N_ENT-1:0] neg;
      xf_type           xf;
   } side_type;

   // numerator magnitudes over a common denominator
   typedef struct packed {
      logic [DEN_W-1:0]             den;
      logic [N_ENT-1:0][DEN_W-1:0]  mag;
      side_type                     side;
   } frac_type;

   // rotation entry magnitudes in q1.30
   typedef struct packed {
      logic [N_ENT-1:0][RATIO_W-1:0] ratio;
      side_type                      side;
   } ratio_type;

endpackage

`default_nettype wire

@@ rtl/core/quaternion_trs_to_affine_matrix_top.sv @@
// Quaternion / scale / translation to 3x4 affine matrix, signed Q16.16.
// Request channel: req_valid, req_stall, req_data (quaternion, per-axis
// scale, translation). A request is taken at a clock edge with req_valid
// high and req_stall low.
// Response channel: rsp_valid, rsp_stall, rsp_data (nine scaled rotation
// entries plus the translation column, bottom row omitted).
// Throughput: one request per cycle while rsp_stall is low. Stages: 5 front
// stages (range reduction, products, sums, numerators, magnitudes), 32
// divider stages (integer step, one quotient bit each for the 30 fraction
// bits, rounding step) and 2 stages for the scale multiply and saturation.
// A zero quaternion yields the identity rotation; results saturate.
// Reset (synchronous, active high) empties the pipeline; no clearing pass.
// When rsp_stall is high the response register holds its value and the
// pipeline keeps filling its empty stages; req_stall rises only once every
// stage holds a request.
`default_nettype none

module quaternion_trs_to_affine_matrix_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire qtam_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output qtam_pkg::rsp_type       rsp_data
);
   import qtam_pkg::*;

   logic      front_ready, div_ready, scale_ready;
   logic      front_valid, div_valid;
   frac_type  front_data;
   ratio_type div_data;

   // products and numerators
   qtam_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (div_ready),
      .out_data  (front_data)
   );

   // pipelined division by squared length
   qtam_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (div_ready),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_ready (scale_ready),
      .out_data  (div_data)
   );

   // scale and saturate
   qtam_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (scale_ready),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

   assign req_stall = !front_ready;

endmodule

`default_nettype wire

@@ rtl/core/qtam_front.sv @@
`default_nettype none

module qtam_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire qtam_pkg::req_type  in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output qtam_pkg::frac_type      out_data
);
   import qtam_pkg::*;

   localparam int NS = 5;

   function automatic logic is_big(logic signed [WORD_W-1:0] a);
      return (a > 32'sh4000_0000) || (a < -32'sh4000_0000);
   endfunction

   // divide by two, truncating toward zero
   function automatic logic [WORD_W-1:0] halve(logic [WORD_W-1:0] a);
      logic [WORD_W-1:0] t;
      t = a + {{(WORD_W-1){1'b0}}, a[WORD_W-1]};
      return {t[WORD_W-1], t[WORD_W-1:1]};
   endfunction

   function automatic logic signed [SQ_W-1:0] smul(logic signed [WORD_W-1:0] a,
                                                   logic signed [WORD_W-1:0] b);
      logic signed [2*WORD_W-1:0] f;
      f = a * b;
      return f[SQ_W-1:0];
   endfunction

   function automatic logic signed [SUM_W-1:0] ext63(logic signed [SQ_W-1:0] a);
      return {a[SQ_W-1], a};
   endfunction

   function automatic logic signed [NUM_W-1:0] ext64(logic signed [SUM_W-1:0] a);
      return {a[SUM_W-1], a};
   endfunction

   // stage valids and advance chain
   logic [NS-1:0] v_ff, v_in, adv;

   always_comb begin
      adv[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS-2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in[0] = adv[0] ? in_valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = adv[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];

   // stage 1: range reduction, scale magnitudes
   logic signed [WORD_W-1:0] q1_ff [4];
   logic signed [WORD_W-1:0] q1_in [4];
   logic signed [WORD_W-1:0] qraw  [4];
   xf_type xf1_ff, xf1_in;
   logic any_big;

   always_comb begin
      qraw[0] = in_data.quat_x;
      qraw[1] = in_data.quat_y;
      qraw[2] = in_data.quat_z;
      qraw[3] = in_data.quat_w;
      any_big = is_big(qraw[0]) || is_big(qraw[1]) || is_big(qraw[2]) || is_big(qraw[3]);
      for (int i = 0; i < 4; i++) begin
         q1_in[i] = any_big ? halve(qraw[i]) : qraw[i];
      end
      xf1_in.sneg  = {in_data.scale_z[WORD_W-1], in_data.scale_y[WORD_W-1],
                      in_data.scale_x[WORD_W-1]};
      xf1_in.smag[0] = in_data.scale_x[WORD_W-1] ? -in_data.scale_x : in_data.scale_x;
      xf1_in.smag[1] = in_data.scale_y[WORD_W-1] ? -in_data.scale_y : in_data.scale_y;
      xf1_in.smag[2] = in_data.scale_z[WORD_W-1] ? -in_data.scale_z : in_data.scale_z;
      xf1_in.shift[0] = in_data.shift_x;
      xf1_in.shift[1] = in_data.shift_y;
      xf1_in.shift[2] = in_data.shift_z;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         q1_ff  <= q1_in;
         xf1_ff <= xf1_in;
      end
   end

   // stage 2: ten component products (xx yy zz ww xy xz yz wx wy wz)
   logic signed [SQ_W-1:0] p2_ff [10];
   xf_type xf2_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         p2_ff[0] <= smul(q1_ff[0], q1_ff[0]);
         p2_ff[1] <= smul(q1_ff[1], q1_ff[1]);
         p2_ff[2] <= smul(q1_ff[2], q1_ff[2]);
         p2_ff[3] <= smul(q1_ff[3], q1_ff[3]);
         p2_ff[4] <= smul(q1_ff[0], q1_ff[1]);
         p2_ff[5] <= smul(q1_ff[0], q1_ff[2]);
         p2_ff[6] <= smul(q1_ff[1], q1_ff[2]);
         p2_ff[7] <= smul(q1_ff[3], q1_ff[0]);
         p2_ff[8] <= smul(q1_ff[3], q1_ff[1]);
         p2_ff[9] <= smul(q1_ff[3], q1_ff[2]);
         xf2_ff   <= xf1_ff;
      end
   end

   // stage 3: pair sums of squares and cross terms
   logic signed [SUM_W-1:0] sq3_ff [6];
   logic signed [SUM_W-1:0] od3_ff [6];
   xf_type xf3_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         sq3_ff[0] <= ext63(p2_ff[0]) + ext63(p2_ff[3]);
         sq3_ff[1] <= ext63(p2_ff[1]) + ext63(p2_ff[2]);
         sq3_ff[2] <= ext63(p2_ff[1]) + ext63(p2_ff[3]);
         sq3_ff[3] <= ext63(p2_ff[0]) + ext63(p2_ff[2]);
         sq3_ff[4] <= ext63(p2_ff[2]) + ext63(p2_ff[3]);
         sq3_ff[5] <= ext63(p2_ff[0]) + ext63(p2_ff[1]);
         od3_ff[0] <= ext63(p2_ff[4]) + ext63(p2_ff[9]);
         od3_ff[1] <= ext63(p2_ff[5]) - ext63(p2_ff[8]);
         od3_ff[2] <= ext63(p2_ff[4]) - ext63(p2_ff[9]);
         od3_ff[3] <= ext63(p2_ff[6]) + ext63(p2_ff[7]);
         od3_ff[4] <= ext63(p2_ff[5]) + ext63(p2_ff[8]);
         od3_ff[5] <= ext63(p2_ff[6]) - ext63(p2_ff[7]);
         xf3_ff    <= xf2_ff;
      end
   end

   // stage 4: squared length and signed numerators
   logic [DEN_W-1:0]        den4_ff;
   logic signed [NUM_W-1:0] num4_ff [N_ENT];
   xf_type xf4_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         den4_ff    <= $unsigned(sq3_ff[0]) + $unsigned(sq3_ff[1]);
         num4_ff[0] <= ext64(sq3_ff[0]) - ext64(sq3_ff[1]);
         num4_ff[1] <= {od3_ff[0], 1'b0};
         num4_ff[2] <= {od3_ff[1], 1'b0};
         num4_ff[3] <= {od3_ff[2], 1'b0};
         num4_ff[4] <= ext64(sq3_ff[2]) - ext64(sq3_ff[3]);
         num4_ff[5] <= {od3_ff[3], 1'b0};
         num4_ff[6] <= {od3_ff[4], 1'b0};
         num4_ff[7] <= {od3_ff[5], 1'b0};
         num4_ff[8] <= ext64(sq3_ff[4]) - ext64(sq3_ff[5]);
         xf4_ff     <= xf3_ff;
      end
   end

   // stage 5: magnitudes, zero quaternion becomes identity
   frac_type f5_ff, f5_in;
   logic [NUM_W-1:0] absn;
   logic zero_len;

   always_comb begin
      zero_len = (den4_ff == '0);
      f5_in.den     = zero_len ? DEN_W'(1) : den4_ff;
      f5_in.side.xf = xf4_ff;
      for (int i = 0; i < N_ENT; i++) begin
         absn = num4_ff[i][NUM_W-1] ? -num4_ff[i] : num4_ff[i];
         f5_in.side.neg[i] = num4_ff[i][NUM_W-1];
         f5_in.mag[i]      = absn[DEN_W-1:0];
      end
      if (zero_len) begin
         f5_in.mag[0] = DEN_W'(1);
         f5_in.mag[4] = DEN_W'(1);
         f5_in.mag[8] = DEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         f5_ff <= f5_in;
      end
   end

   assign out_data = f5_ff;

endmodule

`default_nettype wire

@@ rtl/core/qtam_div.sv @@
`default_nettype none

module qtam_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire qtam_pkg::frac_type  in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output qtam_pkg::ratio_type      out_data
);
   import qtam_pkg::*;

   // integer step, one quotient bit per stage, rounding stage
   localparam int NS = ROT_FRAC + 2;

   logic [NS-1:0] v_ff, v_in, adv;

   always_comb begin
      adv[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS-2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in[0] = adv[0] ? in_valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = adv[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];

   logic [DEN_W-1:0]   den_ff [NS-1];
   logic [DEN_W-1:0]   den_in [NS-1];
   logic [REM_W-1:0]   rem_ff [NS-1][N_ENT];
   logic [REM_W-1:0]   rem_in [NS-1][N_ENT];
   logic [RATIO_W-1:0] q_ff   [NS][N_ENT];
   logic [RATIO_W-1:0] q_in   [NS][N_ENT];
   side_type           side_ff [NS];
   side_type           side_in [NS];

   // restoring division, numerator never exceeds the denominator
   always_comb begin
      logic             ge;
      logic [DEN_W-1:0] sh;
      logic             rnd;
      for (int i = 0; i < N_ENT; i++) begin
         ge           = in_data.mag[i] >= in_data.den;
         q_in[0][i]   = RATIO_W'(ge);
         rem_in[0][i] = ge ? '0 : in_data.mag[i][REM_W-1:0];
      end
      den_in[0]  = in_data.den;
      side_in[0] = in_data.side;
      for (int k = 1; k < NS-1; k++) begin
         den_in[k]  = den_ff[k-1];
         side_in[k] = side_ff[k-1];
         for (int i = 0; i < N_ENT; i++) begin
            sh = {rem_ff[k-1][i], 1'b0};
            if (sh >= den_ff[k-1]) begin
               rem_in[k][i] = REM_W'(sh - den_ff[k-1]);
               q_in[k][i]   = {q_ff[k-1][i][RATIO_W-2:0], 1'b1};
            end else begin
               rem_in[k][i] = sh[REM_W-1:0];
               q_in[k][i]   = {q_ff[k-1][i][RATIO_W-2:0], 1'b0};
            end
         end
      end
      // round to nearest, ties away from zero
      side_in[NS-1] = side_ff[NS-2];
      for (int i = 0; i < N_ENT; i++) begin
         rnd             = {rem_ff[NS-2][i], 1'b0} >= den_ff[NS-2];
         q_in[NS-1][i]   = q_ff[NS-2][i] + RATIO_W'(rnd);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (adv[k]) begin
            q_ff[k]    <= q_in[k];
            side_ff[k] <= side_in[k];
         end
      end
      for (int k = 0; k < NS-1; k++) begin
         if (adv[k]) begin
            den_ff[k] <= den_in[k];
            rem_ff[k] <= rem_in[k];
         end
      end
   end

   always_comb begin
      out_data.side = side_ff[NS-1];
      for (int i = 0; i < N_ENT; i++) begin
         out_data.ratio[i] = q_ff[NS-1][i];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/qtam_scale.sv @@
`default_nettype none

module qtam_scale (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire qtam_pkg::ratio_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output qtam_pkg::rsp_type         out_data
);
   import qtam_pkg::*;

   localparam int NS = 2;

   logic [NS-1:0] v_ff, v_in, adv;

   always_comb begin
      adv[NS-1] = !v_ff[NS-1] || out_ready;
      adv[0]    = !v_ff[0] || adv[1];
      v_in[0]   = adv[0] ? in_valid : v_ff[0];
      v_in[1]   = adv[1] ? v_ff[0] : v_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];

   // stage 1: rotation entry times scale magnitude
   logic [PROD_W-1:0]           p_ff   [N_ENT];
   logic [PROD_W-1:0]           p_in   [N_ENT];
   logic [N_ENT-1:0]            neg_ff, neg_in;
   logic [AXES-1:0][WORD_W-1:0] shift_ff;

   always_comb begin
      logic [RATIO_W+WORD_W-1:0] full;
      for (int i = 0; i < N_ENT; i++) begin
         full      = in_data.ratio[i] * in_data.side.xf.smag[i / AXES];
         p_in[i]   = full[PROD_W-1:0];
         neg_in[i] = in_data.side.neg[i] ^ in_data.side.xf.sneg[i / AXES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         p_ff     <= p_in;
         neg_ff   <= neg_in;
         shift_ff <= in_data.side.xf.shift;
      end
   end

   // stage 2: round, apply sign, saturate into the output register
   logic [WORD_W-1:0] res [N_ENT];
   rsp_type           out_ff, out_in;

   always_comb begin
      logic [PROD_W:0]           sum;
      logic [PROD_W-ROT_FRAC:0]  m;
      for (int i = 0; i < N_ENT; i++) begin
         sum = {1'b0, p_ff[i]} + ((PROD_W+1)'(1) << (ROT_FRAC-1));
         m   = sum[PROD_W:ROT_FRAC];
         if (neg_ff[i] && (m != '0)) begin
            if (m > (PROD_W-ROT_FRAC+1)'(33'h0_8000_0000)) begin
               res[i] = 32'h8000_0000;
            end else begin
               res[i] = -m[WORD_W-1:0];
            end
         end else begin
            if (m > (PROD_W-ROT_FRAC+1)'(33'h0_7FFF_FFFF)) begin
               res[i] = 32'h7FFF_FFFF;
            end else begin
               res[i] = m[WORD_W-1:0];
            end
         end
      end
      out_in.col0_row0 = res[0];
      out_in.col0_row1 = res[1];
      out_in.col0_row2 = res[2];
      out_in.col1_row0 = res[3];
      out_in.col1_row1 = res[4];
      out_in.col1_row2 = res[5];
      out_in.col2_row0 = res[6];
      out_in.col2_row1 = res[7];
      out_in.col2_row2 = res[8];
      out_in.col3_row0 = shift_ff[0];
      out_in.col3_row1 = shift_ff[1];
      out_in.col3_row2 = shift_ff[2];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         out_ff <= out_in;
      end
   end

   assign out_data = out_ff;

endmodule

`default_nettype wire
